// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file dbhd_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while the active-low reset is asserted
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication form, antecedent and consequent on the same edge
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    `CHK_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== rtl/core/dbhd_pkg.sv =====
// types and constants of the debounced brake handle decoder
// no dependencies
package dbhd_pkg;

    localparam int CHANNELS   = 32;
    localparam int CFG_REGS   = 8;
    localparam int CFG_IDX_W  = $clog2(CFG_REGS);
    localparam int TIME_W     = 8;
    localparam int LANES_PER_REG = 32 / TIME_W;

    typedef logic [2:0] t_pos;
    typedef logic [1:0] t_zone;
    typedef logic [TIME_W-1:0] t_time;

    localparam t_pos POS_OC    = 3'd0;
    localparam t_pos POS_RUN   = 3'd1;
    localparam t_pos POS_BRK   = 3'd2;
    localparam t_pos POS_RES   = 3'd3;
    localparam t_pos POS_MUL   = 3'd4;
    localparam t_pos POS_EMC   = 3'd5;
    localparam t_pos POS_OTHER = 3'd6;
    localparam t_pos POS_NONE  = 3'd7;

    localparam t_zone ZONE_NONE = 2'd0;
    localparam t_zone ZONE_ZERO = 2'd1;
    localparam t_zone ZONE_BRK  = 2'd2;
    localparam t_zone ZONE_FAST = 2'd3;

    localparam logic [31:0] FILTER_RESET [CFG_REGS] = '{
        32'h0202_0202, 32'h0202_0202, 32'h0202_0202, 32'h0202_0202,
        32'h0214_1410, 32'h0A02_0214, 32'h0202_0214, 32'h0214_0202
    };

    typedef struct packed {
        t_pos  comb;
        t_pos  port1;
        t_pos  port2;
        t_pos  network;
        t_zone zone;
    } t_decode;

    typedef struct packed {
        logic [CHANNELS-1:0] filt;
        t_decode             dec;
    } t_result;

endpackage

// ===== rtl/core/dbhd_lane.sv =====
// one debounce lane: high-run and low-run counters and the filtered bit
// depends on dbhd_pkg
module dbhd_lane (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_sample,
    input  dbhd_pkg::t_time i_time,
    output logic           o_filt_next
);

    dbhd_pkg::t_time r_high, r_low, n_high, n_low;
    dbhd_pkg::t_time w_inc;
    logic r_filt;

    always_comb begin
        n_high      = r_high;
        n_low       = r_low;
        o_filt_next = r_filt;
        if (i_sample) begin
            w_inc  = r_high + dbhd_pkg::TIME_W'(1);
            n_low  = '0;
            n_high = w_inc;
            if (w_inc >= i_time) begin
                n_high      = i_time;
                o_filt_next = 1'b1;
            end
        end else begin
            w_inc  = r_low + dbhd_pkg::TIME_W'(1);
            n_high = '0;
            n_low  = w_inc;
            if (w_inc >= i_time) begin
                n_low       = i_time;
                o_filt_next = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high <= '0;
            r_low  <= '0;
            r_filt <= 1'b0;
        end else if (i_en) begin
            r_high <= n_high;
            r_low  <= n_low;
            r_filt <= o_filt_next;
        end
    end

endmodule

// ===== rtl/core/dbhd_decode.sv =====
// merging stage: priority decode of the filtered bits, sticky positions and zone
// depends on dbhd_pkg
module dbhd_decode (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic [dbhd_pkg::CHANNELS-1:0]  i_filt,
    output dbhd_pkg::t_decode              o_dec
);

    dbhd_pkg::t_pos  r_port1, r_port2, r_network;
    dbhd_pkg::t_pos  n_port1, n_port2, n_network;
    dbhd_pkg::t_zone r_zone, n_zone;
    dbhd_pkg::t_pos  w_comb;
    logic di04, di05, di07, di08, di09, di10, di20, di21, di22, di23, di30;

    assign di04 = i_filt[3];
    assign di05 = i_filt[4];
    assign di07 = i_filt[6];
    assign di08 = i_filt[7];
    assign di09 = i_filt[8];
    assign di10 = i_filt[9];
    assign di20 = i_filt[19];
    assign di21 = i_filt[20];
    assign di22 = i_filt[21];
    assign di23 = i_filt[22];
    assign di30 = i_filt[29];

    always_comb begin
        n_port1   = r_port1;
        n_port2   = r_port2;
        n_network = r_network;
        if (di04 && !di05) begin
            n_port1 = dbhd_pkg::POS_OC;
        end else if (di10 && !di09) begin
            n_port2 = dbhd_pkg::POS_OC;
        end else if (di20 && !di30) begin
            n_network = dbhd_pkg::POS_OC;
        end else if (di05 && di07 && di08) begin
            n_port1 = dbhd_pkg::POS_RUN;
        end else if (di09 && di10) begin
            n_port1 = dbhd_pkg::POS_BRK;
        end else if (di07 && di09) begin
            n_port1 = dbhd_pkg::POS_RES;
        end else if (di07 && !di09 && !di05) begin
            n_port1 = dbhd_pkg::POS_MUL;
        end else if (di05 && !di07) begin
            n_port1 = dbhd_pkg::POS_EMC;
        end else begin
            n_port1   = dbhd_pkg::POS_OTHER;
            n_port2   = dbhd_pkg::POS_OTHER;
            n_network = dbhd_pkg::POS_OTHER;
        end

        w_comb = dbhd_pkg::POS_OTHER;
        if (n_port1 < w_comb) w_comb = n_port1;
        if (n_port2 < w_comb) w_comb = n_port2;
        if (n_network < w_comb) w_comb = n_network;

        n_zone = r_zone;
        if (di21) begin
            n_zone = dbhd_pkg::ZONE_ZERO;
        end else if (di22) begin
            n_zone = dbhd_pkg::ZONE_BRK;
        end else if (di23) begin
            n_zone = dbhd_pkg::ZONE_FAST;
        end

        o_dec.comb    = w_comb;
        o_dec.port1   = n_port1;
        o_dec.port2   = n_port2;
        o_dec.network = n_network;
        o_dec.zone    = n_zone;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port1   <= dbhd_pkg::POS_NONE;
            r_port2   <= dbhd_pkg::POS_NONE;
            r_network <= dbhd_pkg::POS_NONE;
            r_zone    <= dbhd_pkg::ZONE_NONE;
        end else if (i_en) begin
            r_port1   <= n_port1;
            r_port2   <= n_port2;
            r_network <= n_network;
            r_zone    <= n_zone;
        end
    end

endmodule

// ===== rtl/core/debounced_brake_handle_decoder.sv =====
// top level: filter time registers, 32 debounce lanes, decode stage, output skid
// depends on dbhd_pkg, dbhd_lane, dbhd_decode
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   i_raw_inputs
//  output    out        o_out_valid / i_out_stall o_filtered_inputs .. o_speed_zone
//  config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// one request per cycle while o_in_stall is low; all lanes and the decode update in the accepting cycle
// an accepted result is registered into the output register, or into the skid register while the output is stalled
// a skid register holds one extra result; o_in_stall rises only when it is full
// synchronous active-low reset, no clearing pass
module debounced_brake_handle_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [31:0]                         i_raw_inputs,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [31:0]                         o_filtered_inputs,
    output logic [2:0]                          o_combined_position,
    output logic [2:0]                          o_port1_state,
    output logic [2:0]                          o_port2_state,
    output logic [2:0]                          o_network_state,
    output logic [1:0]                          o_speed_zone,
    input  logic                                i_cfg_we,
    input  logic [dbhd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                         i_cfg_data
);

    logic [31:0] r_filter_times [dbhd_pkg::CFG_REGS];
    logic [dbhd_pkg::CHANNELS-1:0] w_filt_next;
    logic w_accept, w_out_ready;
    dbhd_pkg::t_decode w_dec;
    dbhd_pkg::t_result w_result, r_out, r_skid;
    logic r_out_valid, r_skid_valid;

    assign o_in_stall  = r_skid_valid;
    assign w_accept    = i_in_valid && !r_skid_valid;
    assign w_out_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < dbhd_pkg::CFG_REGS; i++) begin
                r_filter_times[i] <= dbhd_pkg::FILTER_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_filter_times[i_cfg_index] <= i_cfg_data;
        end
    end

    for (genvar g = 0; g < dbhd_pkg::CHANNELS; g++) begin : g_lane
        dbhd_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (w_accept),
            .i_sample    (i_raw_inputs[g]),
            .i_time      (r_filter_times[g / dbhd_pkg::LANES_PER_REG]
                          [(g % dbhd_pkg::LANES_PER_REG) * dbhd_pkg::TIME_W +:
                           dbhd_pkg::TIME_W]),
            .o_filt_next (w_filt_next[g])
        );
    end

    dbhd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_accept),
        .i_filt  (w_filt_next),
        .o_dec   (w_dec)
    );

    assign w_result.filt = w_filt_next;
    assign w_result.dec  = w_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= w_result;
            end
        end else if (w_accept) begin
            r_skid <= w_result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_filtered_inputs   = r_out.filt;
    assign o_combined_position = r_out.dec.comb;
    assign o_port1_state       = r_out.dec.port1;
    assign o_port2_state       = r_out.dec.port2;
    assign o_network_state     = r_out.dec.network;
    assign o_speed_zone        = r_out.dec.zone;

endmodule

// ===== rtl/core/dbhd_checker.sv =====
// port-level checks of the debounced brake handle decoder, bound to the top level
// depends on assert_macros.svh and dbhd_pkg
`include "assert_macros.svh"

module dbhd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_filtered_inputs,
    input logic [2:0]  o_combined_position,
    input logic [2:0]  o_port1_state,
    input logic [1:0]  o_speed_zone
);

    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_filtered_inputs)
            && $stable(o_combined_position),
        "stalled result changed")
    `CHK_IMPLY(a_stall_full, i_clk, i_rst_n, o_in_stall, o_out_valid,
        "input stall without pending result")
    `CHK_IMPLY(a_comb_min, i_clk, i_rst_n,
        o_out_valid && o_port1_state < dbhd_pkg::POS_OTHER,
        o_combined_position <= o_port1_state,
        "combined position above port1")
    `CHK_ASSERT(a_zone_sticky, i_clk, i_rst_n,
        $past(i_rst_n) && $past(o_out_valid) && $past(o_speed_zone) != dbhd_pkg::ZONE_NONE
            && o_out_valid |-> o_speed_zone != dbhd_pkg::ZONE_NONE,
        "speed zone returned to none")

endmodule

bind debounced_brake_handle_decoder dbhd_checker u_dbhd_checker (.*);
